[hw/rtl/segment_lcd_frame_composer_assert.svh]
// -----------------------------------------------------------------------------
// Assertion macros for the segment LCD frame composer
// Implication and next-cycle checks, clocked and reset-qualified.
// -----------------------------------------------------------------------------
`ifndef SEGMENT_LCD_FRAME_COMPOSER_ASSERT_SVH
`define SEGMENT_LCD_FRAME_COMPOSER_ASSERT_SVH

// same-cycle implication
`define SLCD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("slcd check failed");

// implication checked in the next cycle
`define SLCD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("slcd check failed");

`endif

[hw/rtl/slcd_pkg.sv]
// -----------------------------------------------------------------------------
// slcd_pkg
// Constants, glyph table and types for the segment LCD frame composer.
// -----------------------------------------------------------------------------
package slcd_pkg;

    localparam int unsigned SEG_BYTES = 6;

    typedef logic [SEG_BYTES-1:0][7:0] frame_t;

    // big reading limits (tenths)
    localparam logic signed [15:0] BIG_HI_LIMIT   = 16'sd19995;
    localparam logic signed [15:0] BIG_LO_LIMIT   = -16'sd995;
    localparam logic signed [15:0] BIG_POINT_HI   = 16'sd1995;
    localparam logic signed [15:0] BIG_POINT_LO   = -16'sd95;
    // small reading limits
    localparam logic signed [15:0] SMALL_HI_LIMIT = 16'sd99;
    localparam logic signed [15:0] SMALL_LO_LIMIT = -16'sd9;

    // glyphs and single segments
    localparam logic [7:0] GLYPH_H      = 8'h67;
    localparam logic [7:0] GLYPH_I      = 8'h20;
    localparam logic [7:0] GLYPH_L      = 8'hE0;
    localparam logic [7:0] GLYPH_O      = 8'hA6;
    localparam logic [7:0] GLYPH_ZERO   = 8'hF3;
    localparam logic [7:0] SEG_MINUS    = 8'h04;
    localparam logic [7:0] SEG_LEAD_ONE = 8'h08;
    localparam logic [7:0] SEG_POINT    = 8'h08;
    localparam logic [7:0] SEG_PERCENT  = 8'h08;

    // reciprocals for constant division: q = (x * R) >> S, exact over the used range
    localparam logic [25:0] RECIP_675   = 26'd50903317; // x < 2^25
    localparam int unsigned SHIFT_675   = 35;
    localparam logic [14:0] RECIP_10_W  = 15'd26215;    // x <= 20005
    localparam int unsigned SHIFT_10_W  = 18;
    localparam logic [10:0] RECIP_100   = 11'd1311;     // x <= 2000
    localparam int unsigned SHIFT_100   = 17;
    localparam logic [10:0] RECIP_10_N  = 11'd1639;     // x <= 2000
    localparam int unsigned SHIFT_10_N  = 14;
    localparam logic [7:0]  RECIP_10_S  = 8'd205;       // x < 128
    localparam int unsigned SHIFT_10_S  = 11;
    localparam logic [17:0] RECIP_60_S  = 18'd139811;   // x < 86400
    localparam int unsigned SHIFT_60_S  = 23;
    localparam logic [11:0] RECIP_60_M  = 12'd2185;     // x < 1440
    localparam int unsigned SHIFT_60_M  = 17;

    typedef struct packed {
        logic       show_clock;
        logic       battery_low;
        logic       link_up;
        logic [2:0] temp_symbol;
        logic [2:0] smiley_code;
    } side_t;

    typedef struct packed {
        logic neg;
        logic hi;
        logic lo;
        logic round;
    } big_cls_t;

    typedef struct packed {
        logic neg;
        logic hi;
        logic lo;
    } small_cls_t;

    function automatic logic [7:0] digit_glyph(input logic [3:0] d);
        logic [7:0] g;
        case (d)
            4'd0:    g = 8'hF3;
            4'd1:    g = 8'h03;
            4'd2:    g = 8'hB5;
            4'd3:    g = 8'h97;
            4'd4:    g = 8'h47;
            4'd5:    g = 8'hD6;
            4'd6:    g = 8'hF6;
            4'd7:    g = 8'h13;
            4'd8:    g = 8'hF7;
            4'd9:    g = 8'hD7;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

endpackage

[hw/rtl/segment_lcd_frame_composer.sv]
// -----------------------------------------------------------------------------
// segment_lcd_frame_composer
// Builds the six segment bytes of a small LCD from a measurement or a clock
// request and sends a frame only when it changes and the display is on.
// -----------------------------------------------------------------------------
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------
//  s_      | in  | s_tvalid / s_tready | s_tdata (readings), s_tuser (view)
//  m_      | out | m_tvalid / m_tready | m_tdata (segment bytes 0..5)
//  cfg_    | in  | cfg_we              | cfg_wdata (display enable)
//
//  One beat per cycle while m_tready keeps up; a beat goes through the input
//  register and five processing stages to the result register (depth set by
//  the reciprocal-multiply chain that splits seconds into hours and minutes).
//  Beats that give no frame (unchanged or display off) leave no bubble.
//  m_tready low stalls the last stage; earlier empty stages still fill, so
//  up to six beats are taken while a frame waits.
//  aresetn (sync, active low) clears stage valids, the kept battery/link
//  bits and the last-sent frame; display enable comes up set.
//
module segment_lcd_frame_composer
    import slcd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // cfg
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] big_value, [31:16] small_value, [32] percent_sign,
    // [33] battery_low, [34] link_up, [37:35] temp_symbol,
    // [40:38] smiley_code, [72:41] time_seconds, [79:73] zero
    input  logic [79:0] s_tdata,
    // [0] show_clock
    input  logic [0:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] seg_byte0, [15:8] seg_byte1, [23:16] seg_byte2,
    // [31:24] seg_byte3, [39:32] seg_byte4, [47:40] seg_byte5
    output logic [47:0] m_tdata
);

    // ---------------------------------------------------------------- control
    logic [5:0] stage_valid_reg, stage_valid_next;
    logic [5:0] stage_en;
    logic       out_free;
    logic       fire;
    logic       emit;
    logic       m_tvalid_reg, m_tvalid_next;
    frame_t     m_tdata_reg;
    logic       display_enable_reg;
    logic       bat_keep_reg, link_keep_reg;
    frame_t     last_sent_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    // a stage moves when it is empty or the one after it moves
    assign stage_en[5] = !stage_valid_reg[5] || out_free;
    assign stage_en[4] = !stage_valid_reg[4] || stage_en[5];
    assign stage_en[3] = !stage_valid_reg[3] || stage_en[4];
    assign stage_en[2] = !stage_valid_reg[2] || stage_en[3];
    assign stage_en[1] = !stage_valid_reg[1] || stage_en[2];
    assign stage_en[0] = !stage_valid_reg[0] || stage_en[1];

    assign s_tready = stage_en[0];

    always_comb begin
        stage_valid_next[0] = stage_en[0] ? s_tvalid : stage_valid_reg[0];
        stage_valid_next[1] = stage_en[1] ? stage_valid_reg[0] : stage_valid_reg[1];
        stage_valid_next[2] = stage_en[2] ? stage_valid_reg[1] : stage_valid_reg[2];
        stage_valid_next[3] = stage_en[3] ? stage_valid_reg[2] : stage_valid_reg[3];
        stage_valid_next[4] = stage_en[4] ? stage_valid_reg[3] : stage_valid_reg[4];
        stage_valid_next[5] = stage_en[5] ? stage_valid_reg[4] : stage_valid_reg[5];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= '0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // ---------------------------------------------------------------- stage 0
    // input register
    side_t              r0_side_reg;
    logic signed [15:0] r0_big_reg;
    logic signed [15:0] r0_small_reg;
    logic               r0_pct_reg;
    logic [31:0]        r0_secs_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            r0_side_reg.show_clock  <= s_tuser[0];
            r0_side_reg.battery_low <= s_tdata[33];
            r0_side_reg.link_up     <= s_tdata[34];
            r0_side_reg.temp_symbol <= s_tdata[37:35];
            r0_side_reg.smiley_code <= s_tdata[40:38];
            r0_big_reg              <= s_tdata[15:0];
            r0_small_reg            <= s_tdata[31:16];
            r0_pct_reg              <= s_tdata[32];
            r0_secs_reg             <= s_tdata[72:41];
        end
    end

    // ---------------------------------------------------------------- stage 1
    // classify readings, magnitudes; seconds >> 7 divided by 675
    logic [15:0] big_abs, small_abs;
    big_cls_t    big_cls_next;
    logic [14:0] big_mag_next;
    small_cls_t  small_cls_next;
    logic [50:0] q675_prod;

    assign big_abs   = r0_big_reg[15]   ? 16'(-r0_big_reg)   : 16'(r0_big_reg);
    assign small_abs = r0_small_reg[15] ? 16'(-r0_small_reg) : 16'(r0_small_reg);

    always_comb begin
        big_cls_next.neg   = r0_big_reg[15];
        big_cls_next.hi    = r0_big_reg > BIG_HI_LIMIT;
        big_cls_next.lo    = r0_big_reg < BIG_LO_LIMIT;
        big_cls_next.round = (r0_big_reg > BIG_POINT_HI) || (r0_big_reg < BIG_POINT_LO);
        big_mag_next       = big_cls_next.round ? 15'(big_abs + 16'd5) : big_abs[14:0];
        small_cls_next.neg = r0_small_reg[15];
        small_cls_next.hi  = r0_small_reg > SMALL_HI_LIMIT;
        small_cls_next.lo  = r0_small_reg < SMALL_LO_LIMIT;
    end

    assign q675_prod = {26'd0, r0_secs_reg[31:7]} * {25'd0, RECIP_675};

    side_t       r1_side_reg;
    big_cls_t    r1_bcls_reg;
    logic [14:0] r1_big_mag_reg;
    small_cls_t  r1_scls_reg;
    logic [6:0]  r1_small_mag_reg;
    logic        r1_pct_reg;
    logic [24:0] r1_x_reg;
    logic [6:0]  r1_low_reg;
    logic [15:0] r1_q_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            r1_side_reg      <= r0_side_reg;
            r1_bcls_reg      <= big_cls_next;
            r1_big_mag_reg   <= big_mag_next;
            r1_scls_reg      <= small_cls_next;
            r1_small_mag_reg <= small_abs[6:0];
            r1_pct_reg       <= r0_pct_reg;
            r1_x_reg         <= r0_secs_reg[31:7];
            r1_low_reg       <= r0_secs_reg[6:0];
            r1_q_reg         <= q675_prod[SHIFT_675 +: 16];
        end
    end

    // ---------------------------------------------------------------- stage 2
    // rounded whole units, small tens, seconds of the day
    logic [29:0] n_prod;
    logic [10:0] n_next;
    logic [14:0] st_prod;
    logic [25:0] q675_back;
    logic [9:0]  day_rem;

    assign n_prod    = {15'd0, r1_big_mag_reg} * {15'd0, RECIP_10_W};
    assign n_next    = r1_bcls_reg.round ? n_prod[SHIFT_10_W +: 11] : r1_big_mag_reg[10:0];
    assign st_prod   = {8'd0, r1_small_mag_reg} * {7'd0, RECIP_10_S};
    assign q675_back = {10'd0, r1_q_reg} * 26'd675;
    assign day_rem   = 10'(r1_x_reg - q675_back[24:0]);

    side_t       r2_side_reg;
    big_cls_t    r2_bcls_reg;
    logic [10:0] r2_n_reg;
    small_cls_t  r2_scls_reg;
    logic [6:0]  r2_small_mag_reg;
    logic [3:0]  r2_small_tens_reg;
    logic        r2_pct_reg;
    logic [16:0] r2_day_sec_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            r2_side_reg       <= r1_side_reg;
            r2_bcls_reg       <= r1_bcls_reg;
            r2_n_reg          <= n_next;
            r2_scls_reg       <= r1_scls_reg;
            r2_small_mag_reg  <= r1_small_mag_reg;
            r2_small_tens_reg <= st_prod[SHIFT_10_S +: 4];
            r2_pct_reg        <= r1_pct_reg;
            r2_day_sec_reg    <= {day_rem, r1_low_reg};
        end
    end

    // ---------------------------------------------------------------- stage 3
    // n / 100 and n / 10, small-value bytes, minutes of the day
    logic [21:0] h_prod, t_prod;
    logic [6:0]  st_x10;
    logic [3:0]  small_ones;
    logic [7:0]  b4g_next, b5_next;
    logic [34:0] min_prod;

    assign h_prod     = {11'd0, r2_n_reg} * {11'd0, RECIP_100};
    assign t_prod     = {11'd0, r2_n_reg} * {11'd0, RECIP_10_N};
    assign st_x10     = {r2_small_tens_reg, 3'b000} + {2'b00, r2_small_tens_reg, 1'b0};
    assign small_ones = 4'(r2_small_mag_reg - st_x10);
    assign min_prod   = {18'd0, r2_day_sec_reg} * {17'd0, RECIP_60_S};

    always_comb begin
        b5_next = r2_pct_reg ? SEG_PERCENT : 8'h00;
        if (r2_scls_reg.hi) begin
            b4g_next = GLYPH_H;
            b5_next  = b5_next | GLYPH_I;
        end else if (r2_scls_reg.lo) begin
            b4g_next = GLYPH_L;
            b5_next  = b5_next | GLYPH_O;
        end else begin
            b4g_next = r2_scls_reg.neg ? SEG_MINUS : 8'h00;
            if (r2_small_mag_reg > 7'd9) begin
                b4g_next = b4g_next | digit_glyph(r2_small_tens_reg);
            end
            b5_next = b5_next | digit_glyph(small_ones);
        end
    end

    side_t       r3_side_reg;
    big_cls_t    r3_bcls_reg;
    logic [10:0] r3_n_reg;
    logic [4:0]  r3_h_reg;
    logic [7:0]  r3_t_reg;
    logic [7:0]  r3_b4g_reg, r3_b5_reg;
    logic [10:0] r3_min_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            r3_side_reg <= r2_side_reg;
            r3_bcls_reg <= r2_bcls_reg;
            r3_n_reg    <= r2_n_reg;
            r3_h_reg    <= h_prod[SHIFT_100 +: 5];
            r3_t_reg    <= t_prod[SHIFT_10_N +: 8];
            r3_b4g_reg  <= b4g_next;
            r3_b5_reg   <= b5_next;
            r3_min_reg  <= min_prod[SHIFT_60_S +: 11];
        end
    end

    // ---------------------------------------------------------------- stage 4
    // big digits; hours of the day
    logic [10:0] t_x10;
    logic [7:0]  h_x10;
    logic [3:0]  hund_next;
    logic [22:0] hrs_prod;

    assign t_x10    = {r3_t_reg, 3'b000} + {2'b00, r3_t_reg, 1'b0};
    assign h_x10    = {r3_h_reg, 3'b000} + {2'b00, r3_h_reg, 1'b0};
    assign hrs_prod = {12'd0, r3_min_reg} * {11'd0, RECIP_60_M};

    always_comb begin
        if (r3_h_reg >= 5'd20) begin
            hund_next = 4'(r3_h_reg - 5'd20);
        end else if (r3_h_reg >= 5'd10) begin
            hund_next = 4'(r3_h_reg - 5'd10);
        end else begin
            hund_next = r3_h_reg[3:0];
        end
    end

    side_t       r4_side_reg;
    big_cls_t    r4_bcls_reg;
    logic [3:0]  r4_ones_reg, r4_tens_reg, r4_hund_reg;
    logic        r4_gt999_reg, r4_gt99_reg, r4_gt9_reg;
    logic [7:0]  r4_b4g_reg, r4_b5_reg;
    logic [4:0]  r4_hrs_reg;
    logic [10:0] r4_min_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            r4_side_reg  <= r3_side_reg;
            r4_bcls_reg  <= r3_bcls_reg;
            r4_ones_reg  <= 4'(r3_n_reg - t_x10);
            r4_tens_reg  <= 4'(r3_t_reg - h_x10);
            r4_hund_reg  <= hund_next;
            r4_gt999_reg <= r3_n_reg > 11'd999;
            r4_gt99_reg  <= r3_n_reg > 11'd99;
            r4_gt9_reg   <= r3_n_reg > 11'd9;
            r4_b4g_reg   <= r3_b4g_reg;
            r4_b5_reg    <= r3_b5_reg;
            r4_hrs_reg   <= hrs_prod[SHIFT_60_M +: 5];
            r4_min_reg   <= r3_min_reg;
        end
    end

    // ---------------------------------------------------------------- stage 5
    // compose the view bytes; clock view leaves battery/link for the last stage
    logic [10:0] hrs_x60;
    logic [5:0]  mins;
    logic [3:0]  hrs_tens, hrs_ones, min_tens, min_ones;
    frame_t      meas_frame, clk_frame, frame_next;
    side_t       sd;

    assign sd      = r4_side_reg;
    assign hrs_x60 = {r4_hrs_reg, 6'b000000} - {4'b0000, r4_hrs_reg, 2'b00};
    assign mins    = 6'(r4_min_reg - hrs_x60);

    always_comb begin
        if (r4_hrs_reg >= 5'd20) begin
            hrs_tens = 4'd2;
            hrs_ones = 4'(r4_hrs_reg - 5'd20);
        end else if (r4_hrs_reg >= 5'd10) begin
            hrs_tens = 4'd1;
            hrs_ones = 4'(r4_hrs_reg - 5'd10);
        end else begin
            hrs_tens = 4'd0;
            hrs_ones = r4_hrs_reg[3:0];
        end
        if (mins >= 6'd50) begin
            min_tens = 4'd5;
            min_ones = 4'(mins - 6'd50);
        end else if (mins >= 6'd40) begin
            min_tens = 4'd4;
            min_ones = 4'(mins - 6'd40);
        end else if (mins >= 6'd30) begin
            min_tens = 4'd3;
            min_ones = 4'(mins - 6'd30);
        end else if (mins >= 6'd20) begin
            min_tens = 4'd2;
            min_ones = 4'(mins - 6'd20);
        end else if (mins >= 6'd10) begin
            min_tens = 4'd1;
            min_ones = 4'(mins - 6'd10);
        end else begin
            min_tens = 4'd0;
            min_ones = mins[3:0];
        end
    end

    always_comb begin
        // big digits
        if (r4_bcls_reg.hi) begin
            meas_frame[0] = GLYPH_H;
            meas_frame[1] = GLYPH_I;
            meas_frame[2] = 8'h00;
        end else if (r4_bcls_reg.lo) begin
            meas_frame[0] = GLYPH_L;
            meas_frame[1] = GLYPH_O;
            meas_frame[2] = 8'h00;
        end else begin
            meas_frame[0] = r4_bcls_reg.neg ? SEG_MINUS : 8'h00;
            if (r4_gt999_reg) begin
                meas_frame[0] = meas_frame[0] | SEG_LEAD_ONE;
            end
            if (r4_gt99_reg) begin
                meas_frame[0] = meas_frame[0] | digit_glyph(r4_hund_reg);
            end
            meas_frame[1] = r4_bcls_reg.round ? 8'h00 : SEG_POINT;
            meas_frame[1] = meas_frame[1] |
                            (r4_gt9_reg ? digit_glyph(r4_tens_reg) : GLYPH_ZERO);
            meas_frame[2] = digit_glyph(r4_ones_reg);
        end
        // unit, battery, smiley
        meas_frame[2][3] = sd.temp_symbol[1];
        meas_frame[3]    = {sd.temp_symbol[2], sd.battery_low, sd.temp_symbol[0],
                            sd.smiley_code[2], 1'b0, sd.smiley_code[1], 1'b0,
                            sd.smiley_code[0]};
        meas_frame[4]    = r4_b4g_reg;
        meas_frame[4][3] = sd.link_up;
        meas_frame[5]    = r4_b5_reg;
    end

    always_comb begin
        clk_frame[0] = 8'h00;
        clk_frame[1] = digit_glyph(hrs_tens);
        clk_frame[2] = digit_glyph(hrs_ones);
        clk_frame[3] = 8'h00;
        clk_frame[4] = digit_glyph(min_tens);
        clk_frame[5] = digit_glyph(min_ones);
    end

    assign frame_next = sd.show_clock ? clk_frame : meas_frame;

    logic   r5_clk_reg;
    frame_t r5_frame_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            r5_clk_reg   <= sd.show_clock;
            r5_frame_reg <= frame_next;
        end
    end

    // ---------------------------------------------------------------- last stage
    // fold in the kept bits, compare with the last frame sent
    frame_t final_frame;

    always_comb begin
        final_frame = r5_frame_reg;
        if (r5_clk_reg) begin
            final_frame[3][6] = bat_keep_reg;
            final_frame[4][3] = link_keep_reg;
        end
    end

    assign fire = stage_valid_reg[5] && out_free;
    assign emit = display_enable_reg && (final_frame != last_sent_reg);

    assign m_tvalid_next = out_free ? (fire && emit) : m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg       <= 1'b0;
            display_enable_reg <= 1'b1;
            bat_keep_reg       <= 1'b0;
            link_keep_reg      <= 1'b0;
            last_sent_reg      <= '0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                display_enable_reg <= cfg_wdata;
            end
            if (fire) begin
                bat_keep_reg  <= final_frame[3][6];
                link_keep_reg <= final_frame[4][3];
                if (emit) begin
                    last_sent_reg <= final_frame;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            m_tdata_reg <= final_frame;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------------------------------------------------------- checks
`include "segment_lcd_frame_composer_assert.svh"

    // the frame on offer is the one recorded as sent
    `SLCD_ASSERT_IMP(a_offer_is_last, aclk, aresetn, m_tvalid_reg, m_tdata_reg == last_sent_reg)
    // input is refused only with every stage full behind a stalled result
    `SLCD_ASSERT_IMP(a_refuse_full, aclk, aresetn, !s_tready,
                     (&stage_valid_reg) && m_tvalid_reg && !m_tready)
    // nothing new is recorded while a frame waits
    `SLCD_ASSERT_NXT(a_wait_holds, aclk, aresetn, m_tvalid_reg && !m_tready,
                     $stable(last_sent_reg))

endmodule

[dv/tb_segment_lcd_frame_composer.sv]
// -----------------------------------------------------------------------------
// tb_segment_lcd_frame_composer
// Self-checking bench for the segment LCD frame composer. Requests go in as
// stream beats in bursts; a tracker rebuilds the six-byte segment buffer for
// every accepted beat, decides whether a frame is due and checks each frame
// that comes out, byte by byte and in order, against its own prediction.
// -----------------------------------------------------------------------------
module tb_segment_lcd_frame_composer
    import slcd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // cycles to let pass after the last frame before touching the enable
    // register or ending the run (pipeline depth plus margin)
    localparam int DRAIN_CYCLES = 16;

    // kept symbol bits
    localparam logic [7:0] BATTERY_BIT = 8'h40;
    localparam logic [7:0] LINK_BIT    = 8'h08;

    // seven-segment patterns for 0..9, as wired on this panel
    localparam logic [7:0] DIGIT_SEG [0:9] = '{
        8'hF3, 8'h03, 8'hB5, 8'h97, 8'h47, 8'hD6, 8'hF6, 8'h13, 8'hF7, 8'hD7
    };

    // values either side of every display threshold, big and small
    localparam int THRESHOLD_VALS [0:23] = '{
        19995, 19996, 19994, -995, -996, -994, 1995, 1996, 1994, -95, -96, -94,
        999, 1000, 99, 100, -9, -10, 9, 10, -1, 0, 32767, -32768
    };

    typedef struct packed {
        logic              show_clock;
        logic signed [15:0] big_value;
        logic signed [15:0] small_value;
        logic              percent_sign;
        logic              battery_low;
        logic              link_up;
        logic [2:0]        temp_symbol;
        logic [2:0]        smiley_code;
        logic [31:0]       time_seconds;
    } lcd_request_t;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_PULSED,
        SINK_CHOKED
    } sink_mode_t;

    // -------------------------------------------------------------------------
    // Frame tracker: own copy of the segment buffer, the last frame sent and
    // the enable bit; holds the frames still owed by the block.
    // -------------------------------------------------------------------------
    class lcd_frame_tracker;
        frame_t      seg_buf;
        frame_t      last_sent;
        bit          panel_on;
        frame_t      pending_frames[$];
        int unsigned beats_seen;
        int unsigned clock_views;
        int unsigned frames_due;
        int unsigned frames_matched;
        int unsigned errors;

        function new();
            // power-up buffer shows "ooo" on the big digits
            seg_buf   = {8'h00, 8'h00, 8'h00, GLYPH_O, GLYPH_O, GLYPH_O};
            last_sent = '0;
            panel_on  = 1'b1;
        endfunction

        function void set_panel(bit on);
            panel_on = on;
        endfunction

        function void note_request(lcd_request_t r);
            frame_t      b;
            int          n;
            int unsigned mins;
            int unsigned hrs;
            b = seg_buf;
            beats_seen++;
            if (r.show_clock) begin
                // HH:MM; only battery and link survive from the old buffer
                clock_views++;
                mins = (r.time_seconds / 60) % 60;
                hrs  = (r.time_seconds / 3600) % 24;
                b[0] = 8'h00;
                b[1] = DIGIT_SEG[hrs / 10];
                b[2] = DIGIT_SEG[hrs % 10];
                b[3] = b[3] & BATTERY_BIT;
                b[4] = (b[4] & LINK_BIT) | DIGIT_SEG[mins / 10];
                b[5] = DIGIT_SEG[mins % 10];
            end else begin
                // big digits
                n    = $signed(r.big_value);
                b[2] = 8'h00;
                if (n > BIG_HI_LIMIT) begin
                    b[0] = GLYPH_H;
                    b[1] = GLYPH_I;
                end else if (n < BIG_LO_LIMIT) begin
                    b[0] = GLYPH_L;
                    b[1] = GLYPH_O;
                end else begin
                    b[0] = 8'h00;
                    b[1] = 8'h00;
                    if (n > BIG_POINT_HI || n < BIG_POINT_LO) begin
                        // whole units, rounded half up on the magnitude
                        if (n < 0) begin
                            n    = -n;
                            b[0] = SEG_MINUS;
                        end
                        n = (n + 5) / 10;
                    end else begin
                        b[1] = SEG_POINT;
                        if (n < 0) begin
                            n    = -n;
                            b[0] = SEG_MINUS;
                        end
                    end
                    if (n > 999)
                        b[0] = b[0] | SEG_LEAD_ONE;
                    if (n > 99)
                        b[0] = b[0] | DIGIT_SEG[(n / 100) % 10];
                    b[1] = b[1] | ((n > 9) ? DIGIT_SEG[(n / 10) % 10] : GLYPH_ZERO);
                    b[2] = b[2] | DIGIT_SEG[n % 10];
                end
                // small digits, link bit kept until overwritten below
                n    = $signed(r.small_value);
                b[4] = b[4] & LINK_BIT;
                b[5] = r.percent_sign ? SEG_PERCENT : 8'h00;
                if (n > SMALL_HI_LIMIT) begin
                    b[4] = b[4] | GLYPH_H;
                    b[5] = b[5] | GLYPH_I;
                end else if (n < SMALL_LO_LIMIT) begin
                    b[4] = b[4] | GLYPH_L;
                    b[5] = b[5] | GLYPH_O;
                end else begin
                    if (n < 0) begin
                        n    = -n;
                        b[4] = b[4] | SEG_MINUS;
                    end
                    if (n > 9)
                        b[4] = b[4] | DIGIT_SEG[n / 10];
                    b[5] = b[5] | DIGIT_SEG[n % 10];
                end
                // symbols
                b[3][6] = r.battery_low;
                b[2][3] = r.temp_symbol[1];
                b[3][5] = r.temp_symbol[0];
                b[3][7] = r.temp_symbol[2];
                b[3][0] = r.smiley_code[0];
                b[3][2] = r.smiley_code[1];
                b[3][4] = r.smiley_code[2];
                b[4][3] = r.link_up;
            end
            seg_buf = b;
            // a frame only when the panel is on and something changed
            if (panel_on && b != last_sent) begin
                last_sent = b;
                pending_frames.push_back(b);
                frames_due++;
            end
        endfunction

        function void check_frame(frame_t got);
            frame_t want;
            bit     bad;
            if (pending_frames.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] unexpected frame %h", $realtime, got);
                return;
            end
            want = pending_frames.pop_front();
            bad  = 1'b0;
            for (int k = 0; k < SEG_BYTES; k++) begin
                if (got[k] !== want[k])
                    bad = 1'b1;
            end
            if (bad) begin
                errors++;
                if (errors <= 10) begin
                    $display("[%0t] frame mismatch, bytes 5..0", $realtime);
                    $display("    expected %h %h %h %h %h %h", want[5], want[4], want[3],
                             want[2], want[1], want[0]);
                    $display("    actual   %h %h %h %h %h %h", got[5], got[4], got[3],
                             got[2], got[1], got[0]);
                end
            end else begin
                frames_matched++;
            end
        endfunction
    endclass

    // -------------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // -------------------------------------------------------------------------
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;

    lcd_frame_tracker tracker = new();
    lcd_request_t     last_req;

    always #5 aclk = ~aclk;

    segment_lcd_frame_composer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // -------------------------------------------------------------------------
    // Result side. Everything sampled right after the edge holds its pre-edge
    // value, i.e. what the handshake at that edge actually saw.
    // -------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_frame(m_tdata);
    end

    // Receiver back-pressure: a mode is held for a random stretch, from
    // always ready, through random and regular stalls, to mostly choked.
    sink_mode_t  sink_mode = SINK_OPEN;
    int unsigned sink_left = 0;
    logic [4:0]  sink_tick = '0;

    always @(posedge aclk) begin
        if (sink_left == 0) begin
            sink_mode <= sink_mode_t'($urandom_range(0, 3));
            sink_left <= $urandom_range(40, 300);
        end else begin
            sink_left <= sink_left - 1;
        end
        sink_tick <= sink_tick + 5'd1;
        case (sink_mode)
            SINK_OPEN: begin
                m_tready <= 1'b1;
            end
            SINK_RANDOM: begin
                m_tready <= ($urandom_range(0, 9) < 7);
            end
            SINK_PULSED: begin
                m_tready <= (sink_tick < 5'd20);
            end
            default: begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    // -------------------------------------------------------------------------
    // Request builders
    // -------------------------------------------------------------------------
    function automatic lcd_request_t meas_req(int big, int small_v, bit pct, bit bat,
                                              bit link, logic [2:0] sym, logic [2:0] face);
        lcd_request_t r;
        r              = '0;
        r.big_value    = 16'(big);
        r.small_value  = 16'(small_v);
        r.percent_sign = pct;
        r.battery_low  = bat;
        r.link_up      = link;
        r.temp_symbol  = sym;
        r.smiley_code  = face;
        // clock field carries noise; it must not show in measurement view
        r.time_seconds = $urandom();
        return r;
    endfunction

    function automatic lcd_request_t clock_req(logic [31:0] secs);
        lcd_request_t r;
        // measurement fields carry noise; they must not show in clock view
        r              = meas_req($urandom(), $urandom(), 1'($urandom()), 1'($urandom()),
                                  1'($urandom()), 3'($urandom()), 3'($urandom()));
        r.show_clock   = 1'b1;
        r.time_seconds = secs;
        return r;
    endfunction

    // Mostly values near the thresholds and in the displayable ranges, a share
    // of full-width noise, and now and then a straight repeat of the last beat
    // so that the "nothing changed" path is hit.
    function automatic lcd_request_t rand_request(lcd_request_t prev);
        lcd_request_t r;
        int           v;
        if ($urandom_range(0, 9) == 0)
            return prev;
        r = meas_req(0, 0, 1'($urandom()), 1'($urandom()), 1'($urandom()),
                     3'($urandom()), 3'($urandom()));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom();
            4, 5:       v = THRESHOLD_VALS[$urandom_range(0, 23)];
            default:    v = $urandom_range(0, 22000);
        endcase
        r.big_value = 16'((v >= 0 && v <= 22000 && $urandom_range(0, 1)) ? v - 1100 : v);
        case ($urandom_range(0, 9))
            0, 1, 2: v = $urandom();
            3, 4:    v = THRESHOLD_VALS[$urandom_range(0, 23)];
            default: v = $urandom_range(0, 125) - 15;
        endcase
        r.small_value = 16'(v);
        if ($urandom_range(0, 3) == 0) begin
            r.show_clock   = 1'b1;
            r.time_seconds = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 172800);
        end
        return r;
    endfunction

    // -------------------------------------------------------------------------
    // Driving tasks; each is entered just after a rising edge
    // -------------------------------------------------------------------------

    // Present one beat and hold it until taken. A following beat re-asserts
    // tvalid without lowering it, so back-to-back beats see no bubble.
    task automatic push_request(lcd_request_t r);
        s_tvalid <= 1'b1;
        s_tuser  <= r.show_clock;
        s_tdata  <= {7'd0, r.time_seconds, r.smiley_code, r.temp_symbol, r.link_up,
                     r.battery_low, r.percent_sign, r.small_value, r.big_value};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        tracker.note_request(r);
        last_req = r;
    endtask

    // Stop sending, let every owed frame arrive, then give the pipeline time
    // to flush beats that owe nothing.
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (tracker.pending_frames.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES)
            @(posedge aclk);
    endtask

    task automatic write_panel(bit on);
        cfg_we    <= 1'b1;
        cfg_wdata <= on;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        tracker.set_panel(on);
    endtask

    // Random beats in bursts of random length with random gaps; with
    // hold_midway the sender stops half-way until the block has caught up.
    task automatic run_bursts(int count, bit hold_midway);
        int burst_left;
        int gap;
        burst_left = 0;
        for (int i = 0; i < count; i++) begin
            if (hold_midway && i == count / 2)
                drain_pipeline();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap)
                        @(posedge aclk);
                end
            end
            push_request(rand_request(last_req));
            burst_left--;
        end
    endtask

    // -------------------------------------------------------------------------
    // Main sequence
    // -------------------------------------------------------------------------
    initial begin
        last_req = '0;
        repeat (7)
            @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_panel(1'b1);

        // directed: threshold values of both readings, all symbols, clock
        // wrap, unchanged frames and the noise fields of each view
        push_request(meas_req(0, 0, 0, 0, 0, 3'd0, 3'd0));
        push_request(meas_req(32767, 32767, 1, 1, 1, 3'd7, 3'd7));
        push_request(meas_req(-32768, -32768, 0, 0, 0, 3'd0, 3'd0));
        push_request(meas_req(19995, 99, 0, 1, 0, 3'd3, 3'd1));    // 2000, leading one
        push_request(meas_req(19996, 100, 1, 0, 1, 3'd5, 3'd2));   // Hi / Hi
        push_request(meas_req(-995, -9, 0, 1, 1, 3'd2, 3'd4));     // -100
        push_request(meas_req(-996, -10, 1, 0, 0, 3'd4, 3'd5));    // Lo / Lo
        push_request(meas_req(1995, -1, 0, 0, 1, 3'd1, 3'd6));     // 199.5
        push_request(meas_req(1996, 9, 1, 1, 0, 3'd6, 3'd3));      // 200
        push_request(meas_req(-95, 10, 0, 0, 1, 3'd3, 3'd0));      // -9.5
        push_request(meas_req(-96, -5, 1, 1, 1, 3'd5, 3'd7));      // -10, link kept
        push_request(meas_req(5, 0, 1, 1, 1, 3'd0, 3'd1));
        push_request(meas_req(5, 0, 1, 1, 1, 3'd0, 3'd1));         // unchanged
        push_request(clock_req(32'd0));                            // keeps battery/link
        push_request(clock_req(32'hFFFF_FFFF));
        push_request(clock_req(32'd86399));                        // 23:59
        push_request(clock_req(32'd172799));                       // 23:59 again
        push_request(meas_req(999, 50, 0, 1, 0, 3'd3, 3'd1));
        push_request(meas_req(-1, -1, 0, 0, 1, 3'd5, 3'd2));
        push_request(clock_req(32'd47220));                        // 13:07
        push_request(meas_req(12345, 42, 0, 1, 1, 3'd2, 3'd4));
        push_request(clock_req(32'd59));

        // panel off: buffer moves on silently, and the first beat after
        // switching back on is due as a frame
        drain_pipeline();
        write_panel(1'b0);
        push_request(meas_req(100, 1, 0, 0, 0, 3'd0, 3'd0));
        push_request(clock_req(32'd3600));
        drain_pipeline();
        write_panel(1'b1);
        push_request(meas_req(100, 1, 0, 0, 0, 3'd0, 3'd0));

        // random phases, alternating the enable register
        drain_pipeline();
        run_bursts(400, 1'b1);
        drain_pipeline();
        write_panel(1'b0);
        run_bursts(150, 1'b0);
        drain_pipeline();
        write_panel(1'b1);
        run_bursts(350, 1'b0);
        drain_pipeline();
        write_panel(1'b0);
        run_bursts(50, 1'b0);
        drain_pipeline();
        write_panel(1'b1);
        run_bursts(100, 1'b0);
        drain_pipeline();

        $display("Covered %0d request beats (%0d clock views) under six enable changes;",
                 tracker.beats_seen, tracker.clock_views);
        $display("%0d frames matched, %0d beats gave no frame, %0d errors.",
                 tracker.frames_matched, tracker.beats_seen - tracker.frames_due,
                 tracker.errors);
        if (tracker.errors == 0 && tracker.pending_frames.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Watchdog expired, %0d frames still owed", tracker.pending_frames.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
